// ===== rtl/kvdt_pkg.sv =====
package kvdt_pkg;

  localparam int MODE_W = 3;
  localparam int KEY_W = 64;
  localparam int ZOOM_W = 5;
  localparam int POS_W = 32;
  localparam int ACC_W = 24;
  localparam int TIME_W = 32;
  localparam int DELAY_W = 16;
  localparam int CFG_W = 16;
  localparam int FIELDS_W = 190;
  localparam int IN_W = 192;
  localparam int OUT_W = 192;

  localparam logic [2:0] MODE_CLEAR = 3'd0;
  localparam logic [2:0] MODE_ADD = 3'd1;
  localparam logic [2:0] MODE_START = 3'd2;
  localparam logic [2:0] MODE_MARK = 3'd3;
  localparam logic [2:0] MODE_FINISH = 3'd4;

  localparam logic [2:0] RES_DONE = 3'd0;
  localparam logic [2:0] RES_REJECT = 3'd1;
  localparam logic [2:0] RES_STARTED = 3'd2;
  localparam logic [2:0] RES_SHOW = 3'd3;
  localparam logic [2:0] RES_FULL = 3'd4;

  localparam logic [1:0] ST_INVISIBLE = 2'd0;
  localparam logic [1:0] ST_VISIBLE = 2'd1;
  localparam logic [1:0] ST_CANDIDATE = 2'd2;

  localparam logic CFG_MIN_ZOOM = 1'b0;
  localparam logic CFG_HIDE_DELAY = 1'b1;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic commit;
    logic clear_valid;
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic scan_last;
  } status_t;

endpackage

// ===== rtl/keyed_visibility_debounce_tracker_core.sv =====
// channel  dir  fields (low bit first)
// s_axis   in   tuser mode; tdata item_key, zoom, has_position, pos_x, pos_y, accuracy_cm, now_ms
// m_axis   out  tuser result_kind; tdata show event fields (see port comment)
// cfg      in   cfg_we, cfg_index (0 min_zoom, 1 hide_delay_ms), cfg_data
// the input stays not ready from a transfer until its commit: the scan reads
// one table entry per cycle and updates it in the next scan cycle, then a commit
// state loads the result register
// the commit waits while a result held in the output register is not taken, stalling the input
// rst is synchronous; it clears the valid bits and the pass state and loads the default config
module keyed_visibility_debounce_tracker_core #(
  parameter int ENTRIES = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // item_key, zoom, has_position, pos_x, pos_y, accuracy_cm, now_ms, zero fill
  input  logic [kvdt_pkg::IN_W-1:0] s_axis_tdata,
  // mode
  input  logic [kvdt_pkg::MODE_W-1:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // event_key, event_zoom, event_has_position, event_x, event_y,
  // event_accuracy_cm, event_time_ms, zero fill
  output logic [kvdt_pkg::OUT_W-1:0] m_axis_tdata,
  // result_kind
  output logic [kvdt_pkg::MODE_W-1:0] m_axis_tuser,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [kvdt_pkg::CFG_W-1:0] cfg_data
);
  import kvdt_pkg::*;

  cmd_t cmd;
  status_t status;
  logic busy, in_fire, out_free;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (cmd.commit) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  kvdt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_free(out_free),
    .status(status), .cmd(cmd), .busy(busy)
  );

  kvdt_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .in_mode(s_axis_tuser),
    .in_data(s_axis_tdata), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .res_kind(m_axis_tuser), .res_data(m_axis_tdata)
  );
endmodule

// ===== rtl/kvdt_ctrl.sv =====
module kvdt_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic out_free,
  input  kvdt_pkg::status_t status,
  output kvdt_pkg::cmd_t cmd,
  output logic busy
);
  import kvdt_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT} state_t;
  state_t state;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.load = in_fire;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      S_COMMIT: begin
        cmd.commit = out_free;
        cmd.clear_valid = out_free && (status.mode == MODE_CLEAR);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (in_fire) state <= S_SCAN;
        S_SCAN: if (status.scan_last) state <= S_COMMIT;
        S_COMMIT: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/kvdt_dp.sv =====
module kvdt_dp #(
  parameter int ENTRIES = 64
) (
  input  logic clk,
  input  logic rst,
  input  kvdt_pkg::cmd_t cmd,
  output kvdt_pkg::status_t status,
  input  logic [kvdt_pkg::MODE_W-1:0] in_mode,
  input  logic [kvdt_pkg::IN_W-1:0] in_data,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [kvdt_pkg::CFG_W-1:0] cfg_data,
  output logic [kvdt_pkg::MODE_W-1:0] res_kind,
  output logic [kvdt_pkg::OUT_W-1:0] res_data
);
  import kvdt_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  logic [ENTRIES-1:0] valid;
  logic [KEY_W-1:0] key_mem [ENTRIES];
  logic [1:0] stat_mem [ENTRIES];
  logic [ENTRIES-1:0] seen;
  logic [TIME_W-1:0] time_mem [ENTRIES];

  logic [ZOOM_W-1:0] min_zoom;
  logic [DELAY_W-1:0] hide_delay;
  logic pass_active;
  logic [ZOOM_W-1:0] ctx_zoom;
  logic ctx_has;
  logic [POS_W-1:0] ctx_x, ctx_y;
  logic [ACC_W-1:0] ctx_acc;

  logic [2:0] mode;
  logic [KEY_W-1:0] key;
  logic [ZOOM_W-1:0] zoom;
  logic has_pos;
  logic [POS_W-1:0] px, py;
  logic [ACC_W-1:0] acc;
  logic [TIME_W-1:0] now;

  logic [CW-1:0] cnt;
  logic [IW-1:0] idx, idx_q;
  logic [KEY_W-1:0] key_q;
  logic [1:0] stat_q;
  logic [TIME_W-1:0] time_q;
  logic seen_q;
  logic found, free_ok;
  logic [IW-1:0] found_idx, free_idx;
  logic [1:0] found_stat;
  logic proc, hit, show;
  logic [TIME_W-1:0] elapsed;
  logic [MODE_W-1:0] kind_next;
  logic [OUT_W-1:0] data_next;

  // entry read at cnt, updated in the next scan cycle at idx_q
  assign idx = cnt[IW-1:0];
  assign proc = cmd.scan_step && (cnt != '0);
  assign status.mode = mode;
  assign status.scan_last = (cnt == CW'(ENTRIES));

  assign hit = valid[idx_q] && (key_q == key);
  assign elapsed = now - time_q;
  assign show = pass_active && found && (found_stat == ST_INVISIBLE);

  always_comb begin
    kind_next = RES_DONE;
    data_next = '0;
    case (mode)
      MODE_ADD: begin
        if (!found && !free_ok) kind_next = RES_FULL;
      end
      MODE_START: begin
        kind_next = (zoom < min_zoom) ? RES_REJECT : RES_STARTED;
      end
      MODE_MARK: begin
        if (show) begin
          kind_next = RES_SHOW;
          data_next = {2'd0, now, ctx_acc, ctx_y, ctx_x, ctx_has, ctx_zoom, key};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_zoom <= ZOOM_W'(10);
      hide_delay <= DELAY_W'(500);
    end else if (cfg_we) begin
      if (cfg_index == CFG_MIN_ZOOM) min_zoom <= cfg_data[ZOOM_W-1:0];
      else hide_delay <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      pass_active <= 1'b0;
      ctx_zoom <= '0;
      ctx_has <= 1'b0;
      ctx_x <= '0;
      ctx_y <= '0;
      ctx_acc <= '0;
    end else begin
      if (cmd.clear_valid) valid <= '0;
      if (cmd.commit) begin
        case (mode)
          MODE_ADD: if (!found && free_ok) valid[free_idx] <= 1'b1;
          MODE_START: if (zoom >= min_zoom) begin
            pass_active <= 1'b1;
            ctx_zoom <= zoom;
            ctx_has <= has_pos;
            ctx_x <= has_pos ? px : '0;
            ctx_y <= has_pos ? py : '0;
            ctx_acc <= has_pos ? acc : '0;
          end
          MODE_FINISH: pass_active <= 1'b0;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      {now, acc, py, px, has_pos, zoom, key} <= in_data[FIELDS_W-1:0];
      mode <= in_mode;
      cnt <= '0;
      found <= 1'b0;
      free_ok <= 1'b0;
      found_idx <= '0;
      free_idx <= '0;
      found_stat <= ST_INVISIBLE;
    end
    if (cmd.scan_step) begin
      cnt <= cnt + CW'(1);
      idx_q <= idx;
      if (cnt < CW'(ENTRIES)) begin
        key_q <= key_mem[idx];
        stat_q <= stat_mem[idx];
        time_q <= time_mem[idx];
        seen_q <= seen[idx];
      end
    end
    if (proc) begin
      if (hit && !found) begin
        found <= 1'b1;
        found_idx <= idx_q;
        found_stat <= stat_q;
      end
      if (!valid[idx_q] && !free_ok) begin
        free_ok <= 1'b1;
        free_idx <= idx_q;
      end
      if (valid[idx_q]) begin
        if (mode == MODE_START) begin
          if (zoom < min_zoom) stat_mem[idx_q] <= ST_INVISIBLE;
          else seen[idx_q] <= 1'b0;
        end
        if (mode == MODE_FINISH && pass_active) begin
          if (stat_q == ST_VISIBLE && !seen_q) begin
            stat_mem[idx_q] <= ST_CANDIDATE;
            time_mem[idx_q] <= now;
          end else if (stat_q == ST_CANDIDATE) begin
            if (seen_q) stat_mem[idx_q] <= ST_VISIBLE;
            else if (elapsed > TIME_W'(hide_delay)) stat_mem[idx_q] <= ST_INVISIBLE;
          end
        end
      end
    end
    if (cmd.commit) begin
      res_kind <= kind_next;
      res_data <= data_next;
      case (mode)
        MODE_ADD: begin
          if (!found && free_ok) begin
            key_mem[free_idx] <= key;
            stat_mem[free_idx] <= ST_INVISIBLE;
            seen[free_idx] <= 1'b0;
            time_mem[free_idx] <= '0;
          end
        end
        MODE_MARK: begin
          if (pass_active && found) begin
            seen[found_idx] <= 1'b1;
            if (found_stat == ST_INVISIBLE) stat_mem[found_idx] <= ST_VISIBLE;
          end
        end
        default: begin
        end
      endcase
    end
  end
endmodule
